>>> src/utf8_to_ascii_transliterator_macros.svh
// ---------------------------------------------------------------------------
// UTF-8 to ASCII transliterator assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_ASCII_TRANSLITERATOR_MACROS_SVH
`define UTF8_TO_ASCII_TRANSLITERATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define UTF8A_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define UTF8A_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/utf8a_pkg.sv
// ---------------------------------------------------------------------------
// utf8a_pkg
// Types, constants and mapping functions of the UTF-8 to ASCII transliterator.
// ---------------------------------------------------------------------------
`default_nettype none

package utf8a_pkg;

	localparam logic [6:0] SUBST_CHAR = 7'h3F;
	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_DOT   = 7'h2E;
	localparam logic [6:0] CHAR_DASH  = 7'h2D;
	localparam logic [6:0] CHAR_APOS  = 7'h27;
	localparam logic [6:0] CHAR_QUOTE = 7'h22;
	localparam logic [6:0] CHAR_A     = 7'h41;
	localparam logic [6:0] CHAR_C     = 7'h43;
	localparam logic [6:0] CHAR_E     = 7'h45;
	localparam logic [6:0] CHAR_I     = 7'h49;
	localparam logic [6:0] CHAR_N     = 7'h4E;
	localparam logic [6:0] CHAR_O     = 7'h4F;
	localparam logic [6:0] CHAR_U     = 7'h55;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       last_char;
	} out_item_t;

	// A complete sequence, or a truncated one at the end of a string.
	// The fourth byte of a four-byte sequence never affects the result.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            eos;
	} grp_t;

	// Up to three characters decoded from one group.
	typedef struct packed {
		logic [2:0][6:0] chars;
		logic [1:0]      num;
		logic            eos;
	} res_t;

	function automatic logic [2:0] seq_len(input logic [7:0] c);
		logic [2:0] len;
		if (!c[7]) begin
			len = 3'd1;
		end else if (c[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (c[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (c[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd1;
		end
		return len;
	endfunction

	function automatic logic [6:0] single_char(input logic [7:0] c);
		return c[7] ? SUBST_CHAR : c[6:0];
	endfunction

	function automatic logic [6:0] map_two(input logic [10:0] cp);
		logic [7:0] base;
		logic [6:0] low;
		logic [6:0] ch;
		base = cp[7:0] & 8'hDF;
		low  = {1'b0, cp[5], 5'b0};
		if (cp == 11'h0A0) begin
			ch = CHAR_SPACE;
		end else if (cp == 11'h0B7) begin
			ch = CHAR_DOT;
		end else if (cp[10:8] != 3'd0 || cp[7:6] != 2'b11) begin
			ch = SUBST_CHAR;
		end else if (base <= 8'hC5) begin
			ch = CHAR_A + low;
		end else if (base == 8'hC7) begin
			ch = CHAR_C + low;
		end else if (base >= 8'hC8 && base <= 8'hCB) begin
			ch = CHAR_E + low;
		end else if (base >= 8'hCC && base <= 8'hCF) begin
			ch = CHAR_I + low;
		end else if (base == 8'hD1) begin
			ch = CHAR_N + low;
		end else if (base >= 8'hD2 && base <= 8'hD6) begin
			ch = CHAR_O + low;
		end else if (base >= 8'hD9 && base <= 8'hDC) begin
			ch = CHAR_U + low;
		end else begin
			ch = SUBST_CHAR;
		end
		return ch;
	endfunction

	function automatic logic [6:0] map_three(input logic [15:0] cp);
		logic [6:0] ch;
		if (cp == 16'h2013 || cp == 16'h2014) begin
			ch = CHAR_DASH;
		end else if (cp == 16'h2018 || cp == 16'h2019) begin
			ch = CHAR_APOS;
		end else if (cp == 16'h201C || cp == 16'h201D) begin
			ch = CHAR_QUOTE;
		end else if (cp == 16'h2026) begin
			ch = CHAR_DOT;
		end else begin
			ch = SUBST_CHAR;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

>>> src/utf8a_gather.sv
// ---------------------------------------------------------------------------
// utf8a_gather
// Collects the bytes of a multi-byte sequence and registers each complete
// (or end-of-string truncated) group into the first pipeline stage.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8a_gather
	import utf8a_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     src_valid,
	output logic          src_ready,
	input  wire in_item_t src_data,
	input  wire logic     adv,
	output logic          valid_s1,
	output grp_t          grp_s1
);

	logic [2:0][7:0] held_q;
	logic [1:0]      held_cnt_q;
	logic [7:0]      lead;
	logic [2:0]      cnt_next;
	logic            hold;
	logic            accept;
	grp_t            grp_d;

	assign src_ready = !valid_s1 || adv;
	assign accept    = src_valid && src_ready;

	always_comb begin
		lead     = (held_cnt_q == 2'd0) ? src_data.in_byte : held_q[0];
		cnt_next = {1'b0, held_cnt_q} + 3'd1;
		// Keep collecting while the sequence is short, unless the string ends here.
		hold     = (cnt_next < seq_len(lead)) && !src_data.end_of_string;

		grp_d.bytes = held_q;
		case (held_cnt_q)
			2'd0:    grp_d.bytes[0] = src_data.in_byte;
			2'd1:    grp_d.bytes[1] = src_data.in_byte;
			2'd2:    grp_d.bytes[2] = src_data.in_byte;
			default: ;
		endcase
		grp_d.cnt = cnt_next;
		grp_d.eos = src_data.end_of_string;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				held_cnt_q <= hold ? cnt_next[1:0] : 2'd0;
			end
			if (accept && !hold) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold) begin
			held_q[held_cnt_q] <= src_data.in_byte;
		end
		if (accept && !hold) begin
			grp_s1 <= grp_d;
		end
	end

endmodule

`default_nettype wire

>>> src/utf8a_decode.sv
// ---------------------------------------------------------------------------
// utf8a_decode
// Maps one registered group of bytes to one, two or three ASCII characters.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8a_decode
	import utf8a_pkg::*;
(
	input  wire grp_t grp,
	output res_t      res
);

	logic [2:0]  len0;
	logic [10:0] cp2_lead;
	logic [10:0] cp2_tail;
	logic [15:0] cp3;

	always_comb begin
		len0     = seq_len(grp.bytes[0]);
		cp2_lead = {grp.bytes[0][4:0], grp.bytes[1][5:0]};
		cp2_tail = {grp.bytes[1][4:0], grp.bytes[2][5:0]};
		cp3      = {grp.bytes[0][3:0], grp.bytes[1][5:0], grp.bytes[2][5:0]};

		res.chars = {3{SUBST_CHAR}};
		res.num   = 2'd1;
		res.eos   = grp.eos;

		if (grp.cnt >= len0) begin
			case (len0)
				3'd1:    res.chars[0] = single_char(grp.bytes[0]);
				3'd2:    res.chars[0] = map_two(cp2_lead);
				3'd3:    res.chars[0] = map_three(cp3);
				default: res.chars[0] = SUBST_CHAR;
			endcase
		end else begin
			// The string ended inside a sequence: the lead becomes a substitute
			// and the bytes after it are decoded again as a string of their own.
			case (grp.cnt)
				3'd2: begin
					res.num      = 2'd2;
					res.chars[1] = single_char(grp.bytes[1]);
				end
				3'd3: begin
					if (seq_len(grp.bytes[1]) == 3'd2) begin
						res.num      = 2'd2;
						res.chars[1] = map_two(cp2_tail);
					end else begin
						res.num      = 2'd3;
						res.chars[1] = single_char(grp.bytes[1]);
						res.chars[2] = single_char(grp.bytes[2]);
					end
				end
				default: res.num = 2'd1;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/utf8a_emit.sv
// ---------------------------------------------------------------------------
// utf8a_emit
// Result register: loads the decoded characters of one group and hands them
// downstream one per request.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8a_emit
	import utf8a_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic valid_s1,
	input  wire res_t res,
	output logic      adv,
	output logic      dst_valid,
	input  wire logic dst_ready,
	output out_item_t dst_data
);

	res_t       res_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       is_last;
	logic       done;

	assign is_last = (idx_q == res_s2.num - 2'd1);
	assign done    = valid_s2 && dst_ready && is_last;
	assign adv     = valid_s1 && (!valid_s2 || done);

	assign dst_valid          = valid_s2;
	assign dst_data.out_char  = res_s2.chars[idx_q];
	assign dst_data.last_char = res_s2.eos && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
				idx_q    <= 2'd0;
			end else if (done) begin
				valid_s2 <= 1'b0;
			end else if (valid_s2 && dst_ready) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

>>> src/utf8_to_ascii_transliterator.sv
// ---------------------------------------------------------------------------
// utf8_to_ascii_transliterator
// Converts a UTF-8 byte stream to ASCII characters, folding accented Latin-1
// letters, dashes, quotes and ellipsis to plain ASCII and substituting '?'.
// ---------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------
//  src     | src_valid, src_ready | in_item_t  {in_byte, end_of_string}
//  dst     | dst_valid, dst_ready | out_item_t {out_char, last_char}
//
//  One byte is taken per cycle while the first stage can take it; a completed
//  group is registered in the first stage, decoded, and loaded into the result
//  register once that is free, from where its first character is offered.
//  Lead and middle bytes give no character; like any byte they wait only
//  while the first stage is full and cannot move on.
//  A string that ends inside a sequence gives up to three characters, one per
//  cycle from the result register unless dst stalls; src_ready waits for them.
//  Reset clears the byte count and both valid flags; held bytes are not reset.
//
`default_nettype none

module utf8_to_ascii_transliterator
	import utf8a_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      src_valid,
	output logic           src_ready,
	input  wire in_item_t  src_data,
	output logic           dst_valid,
	input  wire logic      dst_ready,
	output out_item_t      dst_data
);

	logic valid_s1;
	grp_t grp_s1;
	res_t res;
	logic adv;

	utf8a_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.grp_s1    (grp_s1)
	);

	utf8a_decode u_decode (
		.grp (grp_s1),
		.res (res)
	);

	utf8a_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.adv       (adv),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

endmodule

`default_nettype wire

>>> src/utf8a_checker.sv
// ---------------------------------------------------------------------------
// utf8a_checker
// Port-level checks of the transliterator, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_ascii_transliterator_macros.svh"

module utf8a_checker
	import utf8a_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      src_ready,
	input wire logic      dst_valid,
	input wire logic      dst_ready,
	input wire out_item_t dst_data
);

	logic dst_wait;
	logic last_taken;

	assign dst_wait   = dst_valid && !dst_ready;
	assign last_taken = dst_valid && dst_ready && dst_data.last_char;

	// A stalled result keeps its character until the request is taken.
	`UTF8A_ASSERT_NEXT(a_dst_hold, dst_wait, dst_valid && $stable(dst_data), "dst not held")

	// The input side only stalls behind a result that is waiting.
	`UTF8A_ASSERT_SAME(a_stall_cause, !src_ready, dst_valid, "src stalled without a result")

	// Taking the final character of a string always frees the input side.
	`UTF8A_ASSERT_SAME(a_last_frees, last_taken, src_ready, "src blocked after last character")

endmodule

bind utf8_to_ascii_transliterator utf8a_checker u_chk (.*);

`default_nettype wire
